>>> rtl/ogg_smb_pkg.sv
// Package for the Ogg seek map builder: constants, op codes and the sequencer microcode.
`timescale 1ns / 1ps
package ogg_smb_pkg;

  // Seek table geometry.
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;

  // Byte spacing between seek points, as a value and as a shift.
  localparam logic [31:0] SEEK_STEP  = 32'h0000_8000;
  localparam int unsigned SEEK_SHIFT = 15;

  // Chunk size register.
  localparam int unsigned CHUNK_W     = 20;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 20'd20000;

  // Request op codes.
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Microcode step addresses.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PKT,
    S_CLR,
    S_MUL,
    S_CHK,
    S_SCAN,
    S_EMIT,
    S_NONE
  } step_e;

  // Branch conditions a control word can test.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_INRANGE,
    C_HIT,
    C_OUT_FREE
  } cond_e;

  // One control word of the sequencer program.
  typedef struct packed {
    cond_e cond;
    step_e jmp_true;
    step_e jmp_false;
    logic  cap_item;
    logic  do_pkt;
    logic  do_clr;
    logic  do_mul;
    logic  do_scan;
    logic  load_res;
    logic  res_none;
  } ctl_t;

  // Read-only program: one control word per step.
  function automatic ctl_t ucode(input step_e s);
    ctl_t w;
    w.cond      = C_ALWAYS;
    w.jmp_true  = S_IDLE;
    w.jmp_false = S_IDLE;
    w.cap_item  = 1'b0;
    w.do_pkt    = 1'b0;
    w.do_clr    = 1'b0;
    w.do_mul    = 1'b0;
    w.do_scan   = 1'b0;
    w.load_res  = 1'b0;
    w.res_none  = 1'b0;
    case (s)
      S_IDLE: begin
        w.cond     = C_DISPATCH;
        w.cap_item = 1'b1;
      end
      S_PKT: begin
        w.do_pkt = 1'b1;
      end
      S_CLR: begin
        w.do_clr = 1'b1;
      end
      S_MUL: begin
        w.do_mul   = 1'b1;
        w.jmp_true = S_CHK;
      end
      S_CHK: begin
        w.cond      = C_INRANGE;
        w.jmp_true  = S_SCAN;
        w.jmp_false = S_NONE;
      end
      S_SCAN: begin
        w.cond      = C_HIT;
        w.do_scan   = 1'b1;
        w.jmp_true  = S_SCAN;
        w.jmp_false = S_EMIT;
      end
      S_EMIT: begin
        w.cond      = C_OUT_FREE;
        w.load_res  = 1'b1;
        w.jmp_true  = S_IDLE;
        w.jmp_false = S_EMIT;
      end
      S_NONE: begin
        w.cond      = C_OUT_FREE;
        w.load_res  = 1'b1;
        w.res_none  = 1'b1;
        w.jmp_true  = S_IDLE;
        w.jmp_false = S_NONE;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/ogg_seek_map_builder_core.sv
// Ogg seek map builder: microcoded sequencer, seek sample memory and result register.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ---------------------------------------------
//   cfg       cfg_we_i                  cfg_wdata_i (chunk size)
//   in        in_valid_i / in_stall_o   op_i, page_start_i, packet_start_i,
//                                       end_sample_i, page_granule_i
//   out       out_valid_o / out_stall_i byte_offset_o, sample_offset_o, entry_number_o,
//                                       last_o, none_left_o, table_full_o
//
// Packet and clear requests have an accept step and an execute step; an unused op is
// dropped in its accept cycle. A read request steps through accept, product, range check,
// scan steps over the leading table entries below the target, and emit.
// A read past the end of the map goes from the range check straight to its none-left result.
// Reset is asynchronous; the seek memory is not cleared, only its fill count.
// The sequencer takes one request at a time; a stalled result holds in the output
// register, and a later read waits in its emit step until that register is free.
`timescale 1ns / 1ps
module ogg_seek_map_builder_core import ogg_smb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CHUNK_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [31:0]         page_start_i,
  input  logic [31:0]         packet_start_i,
  input  logic [31:0]         end_sample_i,
  input  logic [31:0]         page_granule_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         byte_offset_o,
  output logic [31:0]         sample_offset_o,
  output logic [31:0]         entry_number_o,
  output logic                last_o,
  output logic                none_left_o,
  output logic                table_full_o
);

  // Control state.
  step_e              step_q, step_d;
  logic [CHUNK_W-1:0] chunk_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [31:0]        thr_q;
  logic [31:0]        total_q;
  logic [31:0]        next_entry_q;
  logic               overflow_q;
  logic               out_valid_q;

  // Datapath registers.
  logic [31:0]        page_q, pkt_q, nsamp_q, gran_q;
  logic [51:0]        prod_q;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [31:0]        best_bytes_q, best_samp_q;
  logic [31:0]        rdata_q;
  logic [31:0]        seek_mem_q [TABLE_DEPTH];
  logic [31:0]        byte_q, samp_q, entry_q;
  logic               last_q, none_q, full_q;

  // Combinational control.
  ctl_t               ctl;
  logic               in_acc, out_free, hit, in_range, last_w, qualify, room, mem_we;
  logic [52:0]        prod_next;

  assign ctl      = ucode(step_q);
  assign in_stall_o = (step_q != S_IDLE);
  assign in_acc   = in_valid_i && (step_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Packet qualification against the byte threshold.
  assign qualify = (page_q >= thr_q) && (pkt_q >= thr_q) && (pkt_q >= page_q);
  assign room    = cnt_q < CNT_W'(TABLE_DEPTH);
  assign mem_we  = ctl.do_pkt && qualify && room;

  // Map bounds: entry idx exists when idx * chunk < total; it is last when
  // (idx + 1) * chunk reaches total.
  assign in_range  = (chunk_q != '0) && (prod_q < 52'(total_q));
  assign prod_next = {1'b0, prod_q} + 53'(chunk_q);
  assign last_w    = prod_next >= 53'(total_q);

  // Scan continues while the current table entry lies below the target.
  assign hit = (j_q < cnt_q) && (rdata_q < prod_q[31:0]);

  // Scan index, which also addresses the seek memory read.
  always_comb begin
    j_d = j_q;
    if (ctl.do_mul) begin
      j_d = '0;
    end else if (ctl.do_scan && hit) begin
      j_d = j_q + CNT_W'(1);
    end
  end

  // Sequencer branch.
  always_comb begin
    step_d = step_q;
    case (ctl.cond)
      C_ALWAYS:   step_d = ctl.jmp_true;
      C_DISPATCH: begin
        if (in_acc) begin
          case (op_i)
            OP_PACKET: step_d = S_PKT;
            OP_READ:   step_d = S_MUL;
            OP_CLEAR:  step_d = S_CLR;
            default:   step_d = S_IDLE;
          endcase
        end else begin
          step_d = ctl.jmp_false;
        end
      end
      C_INRANGE:  step_d = in_range ? ctl.jmp_true : ctl.jmp_false;
      C_HIT:      step_d = hit ? ctl.jmp_true : ctl.jmp_false;
      C_OUT_FREE: step_d = out_free ? ctl.jmp_true : ctl.jmp_false;
      default:    step_d = S_IDLE;
    endcase
  end

  // Sequencer state, stored map state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= S_IDLE;
      chunk_q      <= CHUNK_RESET;
      cnt_q        <= '0;
      thr_q        <= '0;
      total_q      <= '0;
      next_entry_q <= '0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_we_i) begin
        chunk_q <= cfg_wdata_i;
      end
      if (ctl.do_pkt) begin
        total_q <= gran_q;
        if (qualify) begin
          thr_q <= thr_q + SEEK_STEP;
          if (room) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end else begin
            overflow_q <= 1'b1;
          end
        end
      end
      if (ctl.do_clr) begin
        cnt_q        <= '0;
        thr_q        <= '0;
        total_q      <= '0;
        next_entry_q <= '0;
        overflow_q   <= 1'b0;
      end
      if (ctl.load_res && out_free && !ctl.res_none) begin
        next_entry_q <= next_entry_q + 32'd1;
      end
      if (ctl.load_res && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, target product, scan results and result payload.
  always_ff @(posedge clk_i) begin
    if (ctl.cap_item && in_acc) begin
      page_q  <= page_start_i;
      pkt_q   <= packet_start_i;
      nsamp_q <= end_sample_i;
      gran_q  <= page_granule_i;
    end
    j_q <= j_d;
    if (ctl.do_mul) begin
      prod_q       <= 52'(next_entry_q) * 52'(chunk_q);
      best_bytes_q <= '0;
      best_samp_q  <= '0;
    end else if (ctl.do_scan && hit) begin
      best_bytes_q <= 32'(j_q[ADDR_W-1:0]) << SEEK_SHIFT;
      best_samp_q  <= rdata_q;
    end
    if (ctl.load_res && out_free) begin
      if (ctl.res_none) begin
        byte_q  <= '0;
        samp_q  <= '0;
        entry_q <= '0;
        last_q  <= 1'b0;
        none_q  <= 1'b1;
        full_q  <= 1'b0;
      end else begin
        byte_q  <= best_bytes_q;
        samp_q  <= best_samp_q;
        entry_q <= next_entry_q;
        last_q  <= last_w;
        none_q  <= 1'b0;
        full_q  <= overflow_q;
      end
    end
  end

  // Seek sample memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seek_mem_q[cnt_q[ADDR_W-1:0]] <= nsamp_q;
    end
    rdata_q <= seek_mem_q[j_d[ADDR_W-1:0]];
  end

  assign out_valid_o     = out_valid_q;
  assign byte_offset_o   = byte_q;
  assign sample_offset_o = samp_q;
  assign entry_number_o  = entry_q;
  assign last_o          = last_q;
  assign none_left_o     = none_q;
  assign table_full_o    = full_q;

  // The scan never walks past the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_SCAN) |-> (j_q <= cnt_q))
    else $error("seek scan index beyond table fill count");

  // The fill count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("seek table fill count beyond depth");

  // An exhausted-map result carries no other information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_left_o) |->
      (byte_offset_o == '0 && sample_offset_o == '0 && entry_number_o == '0 &&
       !last_o && !table_full_o))
    else $error("exhausted-map result with nonzero fields");

  // Every delivered map entry advances the entry counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_EMIT && out_free) |=> (next_entry_q == $past(next_entry_q) + 32'd1))
    else $error("entry counter did not advance after a map entry");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the Ogg seek map builder core.
`timescale 1ns / 1ps
module tb;
  import ogg_smb_pkg::*;

  // The op code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] page_start;
    logic [31:0] packet_start;
    logic [31:0] end_sample;
    logic [31:0] page_granule;
    bit          back_to_back;
  } request_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic [31:0] sample_offset;
    logic [31:0] entry_number;
    logic        last;
    logic        none_left;
    logic        table_full;
  } map_entry_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CHUNK_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_PACKET;
  logic [31:0]        page_start_i = '0;
  logic [31:0]        packet_start_i = '0;
  logic [31:0]        end_sample_i = '0;
  logic [31:0]        page_granule_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        byte_offset_o;
  logic [31:0]        sample_offset_o;
  logic [31:0]        entry_number_o;
  logic               last_o;
  logic               none_left_o;
  logic               table_full_o;

  ogg_seek_map_builder_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .page_start_i   (page_start_i),
    .packet_start_i (packet_start_i),
    .end_sample_i   (end_sample_i),
    .page_granule_i (page_granule_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_offset_o  (byte_offset_o),
    .sample_offset_o(sample_offset_o),
    .entry_number_o (entry_number_o),
    .last_o         (last_o),
    .none_left_o    (none_left_o),
    .table_full_o   (table_full_o)
  );

  // Clock generation.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Our own copy of the seek map state and the chunk size register.
  logic [CHUNK_W-1:0] chunk_sz = CHUNK_RESET;
  logic [31:0]        seek_mem [TABLE_DEPTH];
  int unsigned        seek_fill = 0;
  logic [31:0]        byte_thr = '0;
  logic [31:0]        total_smp = '0;
  logic [31:0]        next_ent = '0;
  logic               dropped = 1'b0;

  request_t    pending[$];
  map_entry_t  entries_due[$];
  int unsigned queued_cnt = 0;
  int unsigned mismatches = 0;

  // Stream position used to build well-formed packet sequences.
  logic [31:0] s_pos = '0;
  logic [31:0] s_page = '0;
  logic [31:0] s_smp = '0;

  // Random idle length: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_map();
    seek_fill = 0;
    byte_thr  = '0;
    total_smp = '0;
    next_ent  = '0;
    dropped   = 1'b0;
  endfunction

  // Update the seek map for one accepted request and queue the entry a read returns.
  function automatic void track_request(request_t r);
    map_entry_t      e;
    longint unsigned n_ent;
    logic [31:0]     target;
    e = '0;
    case (r.op)
      OP_PACKET: begin
        total_smp = r.page_granule;
        if (r.page_start >= byte_thr && r.packet_start >= byte_thr &&
            r.packet_start >= r.page_start) begin
          if (seek_fill < TABLE_DEPTH) begin
            seek_mem[seek_fill] = r.end_sample;
            seek_fill++;
          end else begin
            dropped = 1'b1;
          end
          byte_thr = byte_thr + SEEK_STEP;
        end
      end
      OP_CLEAR: begin
        clear_map();
      end
      OP_READ: begin
        n_ent = (chunk_sz == '0) ? 64'd0 :
                (64'(total_smp) + 64'(chunk_sz) - 64'd1) / 64'(chunk_sz);
        if (64'(next_ent) >= n_ent) begin
          e.none_left = 1'b1;
        end else begin
          target = 32'(64'(next_ent) * 64'(chunk_sz));
          // The entry is the last one of the leading run that lies below the target.
          for (int j = 0; j < int'(seek_fill) && seek_mem[j] < target; j++) begin
            e.byte_offset   = 32'(j) << SEEK_SHIFT;
            e.sample_offset = seek_mem[j];
          end
          e.entry_number = next_ent;
          e.last         = (64'(next_ent) + 64'd1 == n_ent);
          e.table_full   = dropped;
          next_ent       = next_ent + 32'd1;
        end
        entries_due.insert(entries_due.size(), e);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_req(input logic [1:0] op, input logic [31:0] page,
                                  input logic [31:0] pkt, input logic [31:0] smp,
                                  input logic [31:0] gran, input bit b2b = 1'b0);
    pending.insert(pending.size(), '{op, page, pkt, smp, gran, b2b});
    queued_cnt++;
  endfunction

  // Alternating calm and busy stretches; no idling on either side while calm.
  bit          calm = 1'b0;
  int unsigned calm_left = 0;
  always @(posedge clk_i) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else begin
      calm      <= ~calm;
      calm_left <= calm ? $urandom_range(300, 900) : $urandom_range(60, 200);
    end
  end

  // One long receiver hold-off, started on request from the stimulus.
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Request driver: offers queued requests with random gaps between them.
  request_t    cur_req;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_request(cur_req);
        gap_left = (cur_req.back_to_back || calm) ? 0 : pick_gap();
      end
      if (in_valid_i && in_stall_o) begin
        // Stalled: hold the request as it is.
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0) begin
        cur_req = pending.pop_front();
        op_i           <= cur_req.op;
        page_start_i   <= cur_req.page_start;
        packet_start_i <= cur_req.packet_start;
        end_sample_i   <= cur_req.end_sample;
        page_granule_i <= cur_req.page_granule;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: checks each map entry against the oldest one due and drives the stall.
  map_entry_t  got_entry;
  map_entry_t  want_entry;
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_entry = {byte_offset_o, sample_offset_o, entry_number_o,
                     last_o, none_left_o, table_full_o};
        if (entries_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: map entry with none due", $realtime);
            $display("  actual   bytes=%h samples=%h entry=%0d last=%b none=%b full=%b",
                     got_entry.byte_offset, got_entry.sample_offset,
                     got_entry.entry_number, got_entry.last, got_entry.none_left,
                     got_entry.table_full);
          end
        end else begin
          want_entry = entries_due.pop_front();
          if (got_entry !== want_entry) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: map entry mismatch", $realtime);
              $display("  expected bytes=%h samples=%h entry=%0d last=%b none=%b full=%b",
                       want_entry.byte_offset, want_entry.sample_offset,
                       want_entry.entry_number, want_entry.last, want_entry.none_left,
                       want_entry.table_full);
              $display("  actual   bytes=%h samples=%h entry=%0d last=%b none=%b full=%b",
                       got_entry.byte_offset, got_entry.sample_offset,
                       got_entry.entry_number, got_entry.last, got_entry.none_left,
                       got_entry.table_full);
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left != 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Wait until every request is taken and every entry has come back, then let the
  // last packet or clear finish, since those give no result.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || entries_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_chunk(input logic [CHUNK_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    chunk_sz = v;
    @(negedge clk_i);
  endtask

  // One packet sequence with random content, some broken packets and noise, then
  // reads: as many as the map has entries, at most twelve, plus one or two.
  task automatic gen_stream(input int unsigned step_max);
    int unsigned     n_reads;
    logic [31:0]     gran;
    longint unsigned n_ent;
    if ($urandom_range(0, 99) < 85) begin
      add_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      s_pos  = '0;
      s_page = '0;
      s_smp  = '0;
    end
    gran = s_smp;
    repeat ($urandom_range(4, 60)) begin
      s_pos = s_pos + $urandom_range(200, 12000);
      if ($urandom_range(0, 2) == 0) s_page = s_pos;
      s_smp = s_smp + $urandom_range(64, step_max);
      gran  = s_smp + $urandom_range(0, 2048);
      case ($urandom_range(0, 19))
        0: add_req(OP_PACKET, $urandom, $urandom, $urandom, $urandom);
        1: add_req(OP_PACKET, s_page, s_page - $urandom_range(1, 100), s_smp, gran);
        2: add_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        3: add_req(OP_READ, $urandom, $urandom, $urandom, $urandom);
        default: add_req(OP_PACKET, s_page, s_pos, s_smp, gran);
      endcase
    end
    n_ent   = (chunk_sz == '0) ? 64'd0 :
              (64'(gran) + 64'(chunk_sz) - 64'd1) / 64'(chunk_sz);
    n_reads = ((n_ent > 12) ? 12 : int'(n_ent)) + $urandom_range(1, 2);
    repeat (n_reads) add_req(OP_READ, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Stimulus and end of run.
  initial begin
    logic [CHUNK_W-1:0] v;
    int unsigned        step_max;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset chunk size.
    add_req(OP_READ, '0, '0, '0, '0);                     // empty map
    add_req(OP_UNUSED, '1, '1, '1, '1);                   // ignored op
    add_req(OP_PACKET, '0, '0, '0, '0);                   // both starts at zero threshold
    add_req(OP_READ, '0, '0, '0, '0);                     // zero total gives no entries
    add_req(OP_PACKET, 32'h8000, 32'h7FFF, 32'd1, 32'd5); // packet below threshold
    add_req(OP_PACKET, 32'h9000, 32'h8FFF, 32'd777, 32'd10); // packet before its page
    add_req(OP_PACKET, 32'h8000, 32'h8000, 32'd15000, 32'd50000);
    add_req(OP_PACKET, 32'h10000, 32'h18000, 32'd30000, 32'd60000);
    add_req(OP_PACKET, 32'h18000, 32'h18000, 32'd30000, 32'd60001); // repeated sample
    add_req(OP_PACKET, '1, '1, '1, 32'd60001);            // all-ones offsets and sample
    repeat (5) add_req(OP_READ, '1, '1, '1, '1);          // four entries, then none left
    add_req(OP_UNUSED, '0, '0, '0, '0);
    add_req(OP_CLEAR, '1, '1, '1, '1);
    add_req(OP_READ, '0, '0, '0, '0);
    add_req(OP_PACKET, '0, '0, 32'd5, '1);                // largest running total
    repeat (2) add_req(OP_READ, '0, '0, '0, '0);
    wait_idle();

    // Random part over several chunk sizes, the extremes included.
    queued_cnt = 0;
    for (int p = 0; p < int'(RANDOM_PHASES); p++) begin
      case (p)
        0: v = 20'd1;
        1: v = 20'hFFFFF;
        2: v = '0;
        3, 4: v = CHUNK_W'($urandom_range(2000, 30000));
        5: v = CHUNK_W'($urandom_range(1, 20'hFFFFF));
        default: v = CHUNK_RESET;
      endcase
      if (p == 3) hold_go = 1'b1;
      write_chunk(v);
      step_max = (chunk_sz > 16384) ? int'(chunk_sz) / 8 : 2048;
      while (queued_cnt < (p + 1) * RANDOM_ITEMS / RANDOM_PHASES) gen_stream(step_max);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #(50_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
